@@ design/chash_pkg.sv @@
// shared constants, types and state encoding for the chained hash table
package chash_pkg;

  // default sizing, handed down from the top level
  localparam int BUCKETS_DEF  = 16;
  localparam int SLOTS_DEF    = 8;
  localparam int KEY_BITS_DEF = 16;

  // fixed field widths
  localparam int CFG_W     = 5;
  localparam int KIND_W    = 2;
  localparam int REMOVED_W = 4;
  localparam int BIDX_W    = 4;

  // bucket count after reset
  localparam logic [CFG_W-1:0] BCOUNT_RESET = 5'd16;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_FILL,
    ST_SCAN,
    ST_UPD,
    ST_DONE
  } state_t;

  // one result transaction
  typedef struct packed {
    logic                 status;
    logic                 found;
    logic [REMOVED_W-1:0] removed_count;
    logic [BIDX_W-1:0]    bucket_index;
  } result_t;

endpackage

@@ design/chash_ifs.sv @@
// channel interfaces: operation input, result output and configuration write

// operation channel
interface chash_in_if #(
  parameter int KEY_BITS = chash_pkg::KEY_BITS_DEF
);
  import chash_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

// result channel
interface chash_out_if;
  import chash_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic                 found;
  logic [REMOVED_W-1:0] removed_count;
  logic [BIDX_W-1:0]    bucket_index;

  modport source (output valid, output status, output found, output removed_count,
                  output bucket_index, input ready);
  modport sink   (input valid, input status, input found, input removed_count,
                  input bucket_index, output ready);
endinterface

// bucket count write channel
interface chash_cfg_if;
  import chash_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/chash_mod.sv @@
// iterative restoring remainder unit: key modulo bucket count, one bit a cycle
module chash_mod #(
  parameter int KEY_BITS = chash_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [KEY_BITS-1:0]        dividend,
  input  logic [chash_pkg::CFG_W-1:0] divisor,
  output logic                       done,
  output logic [chash_pkg::CFG_W-1:0] rem
);
  import chash_pkg::*;

  localparam int CNT_W = $clog2(KEY_BITS);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [KEY_BITS-1:0] shift_r;
  logic [CFG_W-1:0]    div_r;
  logic [CFG_W-1:0]    rem_r;
  logic [CFG_W-1:0]    rem_nxt;
  logic [CFG_W:0]      trial;

  // bring down the next key bit and subtract once if it fits
  always_comb begin
    trial = {rem_r, shift_r[KEY_BITS-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CFG_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = CFG_W'(trial);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      div_r   <= divisor;
      rem_r   <= '0;
      cnt_r   <= CNT_W'(KEY_BITS - 1);
    end else if (busy_r) begin
      shift_r <= shift_r << 1;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ design/chash_engine.sv @@
// bucket sequencer with slot and fill memories: scan, compaction and append
module chash_engine #(
  parameter int BUCKETS  = chash_pkg::BUCKETS_DEF,
  parameter int SLOTS    = chash_pkg::SLOTS_DEF,
  parameter int KEY_BITS = chash_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [chash_pkg::CFG_W-1:0]  bucket_m,
  input  logic                         in_fire,
  input  logic [chash_pkg::KIND_W-1:0] in_kind,
  input  logic [KEY_BITS-1:0]          in_key,
  output logic                         busy,
  output logic                         res_valid,
  output chash_pkg::result_t           res,
  input  logic                         res_take
);
  import chash_pkg::*;

  localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W    = $clog2(SLOTS + 1);
  localparam int SLOT_SPAN = 1 << SLOT_W;
  localparam int MEM_DEPTH = BUCKETS * SLOT_SPAN;
  localparam int ADDR_W    = BKT_W + SLOT_W;

  state_t state_r, state_nxt;

  logic [KIND_W-1:0]   kind_r;
  logic [KEY_BITS-1:0] key_r;
  logic [BKT_W-1:0]    bkt_r;
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   rd_idx_r;
  logic [FILL_W-1:0]   wr_idx_r;
  logic [FILL_W-1:0]   removed_r;
  logic                pend_r;
  logic                found_r;
  logic                status_r;

  // remainder unit
  logic             mod_done;
  logic [CFG_W-1:0] mod_rem;

  chash_mod #(.KEY_BITS(KEY_BITS)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .dividend (in_key),
    .divisor  (bucket_m),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // memories
  logic [KEY_BITS-1:0] slot_mem [MEM_DEPTH];
  logic [FILL_W-1:0]   fill_mem [BUCKETS];
  logic [BUCKETS-1:0]  fill_valid_r;
  logic [KEY_BITS-1:0] slot_q_r;
  logic [FILL_W-1:0]   fill_q_r;
  logic                fill_vq_r;

  logic                slot_re, slot_we, fill_we;
  logic [ADDR_W-1:0]   slot_ra, slot_wa;
  logic [KEY_BITS-1:0] slot_wd;
  logic [FILL_W-1:0]   fill_wd;
  logic [BKT_W-1:0]    fill_ra;
  logic [FILL_W-1:0]   fill_cur;
  logic                issue, hit, full;
  logic                is_ins, is_del;

  assign is_ins  = (kind_r == KIND_INSERT);
  assign is_del  = (kind_r == KIND_DELETE);
  assign issue   = (rd_idx_r != fill_r);
  assign hit     = pend_r && (slot_q_r == key_r);
  assign full    = (fill_r == FILL_W'(SLOTS));
  assign fill_ra = BKT_W'(mod_rem);

  // fill count as read: unwritten buckets are empty, counts above the slot count are clamped to it
  always_comb begin
    if (!fill_vq_r) begin
      fill_cur = '0;
    end else if (fill_q_r > FILL_W'(SLOTS)) begin
      fill_cur = FILL_W'(SLOTS);
    end else begin
      fill_cur = fill_q_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_MOD;
      ST_MOD:  if (mod_done) state_nxt = ST_FILL;
      ST_FILL: state_nxt = ST_SCAN;
      ST_SCAN: if (!issue && !pend_r) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_DONE;
      ST_DONE: if (res_take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    slot_re = 1'b0;
    slot_we = 1'b0;
    fill_we = 1'b0;
    slot_ra = {bkt_r, rd_idx_r[SLOT_W-1:0]};
    slot_wa = {bkt_r, wr_idx_r[SLOT_W-1:0]};
    slot_wd = slot_q_r;
    fill_wd = wr_idx_r;
    unique case (state_r)
      ST_SCAN: begin
        slot_re = issue;
        // keep survivors packed at the front of the bucket
        slot_we = pend_r && !hit && is_del;
      end
      ST_UPD: begin
        if (is_ins && !full) begin
          slot_we = 1'b1;
          slot_wa = {bkt_r, fill_r[SLOT_W-1:0]};
          slot_wd = key_r;
          fill_we = 1'b1;
          fill_wd = fill_r + 1'b1;
        end else if (is_del) begin
          fill_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_r       <= 1'b0;
      fill_valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SCAN) && issue;
      if (fill_we) fill_valid_r[bkt_r] <= 1'b1;
    end
  end

  // slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_q_r <= slot_mem[slot_ra];
  end

  // fill memory, read as the bucket becomes known
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[bkt_r] <= fill_wd;
    if (mod_done) begin
      fill_q_r  <= fill_mem[fill_ra];
      fill_vq_r <= fill_valid_r[fill_ra];
    end
  end

  // operation datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_kind;
      key_r  <= in_key;
    end
    if (mod_done) bkt_r <= BKT_W'(mod_rem);
    unique case (state_r)
      ST_FILL: begin
        fill_r    <= fill_cur;
        rd_idx_r  <= '0;
        wr_idx_r  <= '0;
        removed_r <= '0;
        found_r   <= 1'b0;
        status_r  <= 1'b0;
      end
      ST_SCAN: begin
        if (issue) rd_idx_r <= rd_idx_r + 1'b1;
        if (hit) begin
          found_r   <= 1'b1;
          removed_r <= is_del ? removed_r + 1'b1 : removed_r;
        end else if (pend_r && is_del) begin
          wr_idx_r <= wr_idx_r + 1'b1;
        end
      end
      ST_UPD: begin
        if (is_ins && full) status_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    res.status        = status_r;
    res.found         = found_r && (kind_r != KIND_NONE);
    res.removed_count = (32'(removed_r) > 32'd15) ? 4'hF : REMOVED_W'(removed_r);
    res.bucket_index  = BIDX_W'(bkt_r);
  end

  assign res_valid = (state_r == ST_DONE);
  assign busy      = (state_r != ST_IDLE);

endmodule

@@ design/chained_hash_table.sv @@
// top level: bucket count register, bucket engine and result output register
// flow: remainder, fill read, slot scan, update, then the result output register; the time from
//   input transaction to result valid is set by the bit-serial remainder and one slot read a cycle
// throughput: one operation at a time, a new input is taken only once the engine is back in idle
// reset: fill counts cleared and bucket count set to 16 at once, no clearing pass
module chained_hash_table #(
  parameter int BUCKETS  = chash_pkg::BUCKETS_DEF,
  parameter int SLOTS    = chash_pkg::SLOTS_DEF,
  parameter int KEY_BITS = chash_pkg::KEY_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  chash_in_if.sink    in_ch,
  chash_out_if.source out_ch,
  chash_cfg_if.sink   cfg_ch
);
  import chash_pkg::*;

  logic [CFG_W-1:0] bucket_count_r;
  logic [CFG_W-1:0] bucket_m;
  logic             in_fire;
  logic             eng_busy;
  logic             eng_res_valid;
  logic             res_take;
  result_t          eng_res;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;

  // bucket count register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BCOUNT_RESET;
    end else if (cfg_ch.valid) begin
      bucket_count_r <= cfg_ch.data;
    end
  end

  // buckets in use, held between one and the table size
  always_comb begin
    priority if (bucket_count_r == '0) begin
      bucket_m = CFG_W'(1);
    end else if (int'(bucket_count_r) > BUCKETS) begin
      bucket_m = CFG_W'(BUCKETS);
    end else begin
      bucket_m = bucket_count_r;
    end
  end

  // input transaction
  assign in_ch.ready = !eng_busy;
  assign in_fire     = in_ch.valid && !eng_busy;

  chash_engine #(
    .BUCKETS  (BUCKETS),
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .bucket_m  (bucket_m),
    .in_fire   (in_fire),
    .in_kind   (in_ch.kind),
    .in_key    (in_ch.key),
    .busy      (eng_busy),
    .res_valid (eng_res_valid),
    .res       (eng_res),
    .res_take  (res_take)
  );

  // output register, refilled in the cycle the old result leaves
  assign res_take = eng_res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_res_r <= eng_res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.found         = out_res_r.found;
  assign out_ch.removed_count = out_res_r.removed_count;
  assign out_ch.bucket_index  = out_res_r.bucket_index;

endmodule

@@ design/chash_checker.sv @@
// port-level checks for the chained hash table and their bind
module chash_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_status,
  input logic                            out_found,
  input logic [chash_pkg::REMOVED_W-1:0] out_removed_count,
  input logic [chash_pkg::BIDX_W-1:0]    out_bucket_index
);
  import chash_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] outstanding_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // operations taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding_r <= outstanding_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      outstanding_r <= outstanding_r - 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found)
      && $stable(out_removed_count) && $stable(out_bucket_index))
    else $error("result changed while stalled");

  // every result has a transaction behind it, and at most two are in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> outstanding_r != 2'd0)
    else $error("result without an accepted operation");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r != 2'd3)
    else $error("too many operations in flight");

  // removals imply the key was present, a dropped insert removes nothing
  a_removed_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_removed_count != '0) |-> out_found && !out_status)
    else $error("removal reported without the key present");

endmodule

bind chained_hash_table chash_checker u_chash_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_found         (out_ch.found),
  .out_removed_count (out_ch.removed_count),
  .out_bucket_index  (out_ch.bucket_index)
);
